[rtl/tns_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_pkg
// Shared types and constants for the target namespace scanner: scan phases,
// match patterns, and the structs for the window's hits and the control's results.
// ----------------------------------------------------------------------------
package tns_pkg;

  // Length of the targetNamespace token; the window keeps the bytes before
  // the current one, which is all the longest pattern needs.
  localparam int TokLen   = 15;
  localparam int WinDepth = TokLen - 1;

  localparam logic [7:0] TokPat [TokLen] = '{
    "t", "a", "r", "g", "e", "t", "N", "a", "m", "e", "s", "p", "a", "c", "e"
  };

  localparam logic [7:0] ChLt     = 8'h3c;  // <
  localparam logic [7:0] ChBang   = 8'h21;  // !
  localparam logic [7:0] ChDash   = 8'h2d;  // -
  localparam logic [7:0] ChGt     = 8'h3e;  // >
  localparam logic [7:0] ChDquote = 8'h22;  // "
  localparam logic [7:0] ChSquote = 8'h27;  // '

  // Bytes seen since a comment opener, saturating at this value.
  localparam logic [1:0] OpenSat = 2'd3;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_QUOTE,
    PH_NAME,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic open_hit;   // current byte completes "<!--"
    logic close_hit;  // current byte completes "-->"
    logic tok_hit;    // current byte completes the token
  } tns_hits_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] name_byte;
    logic       is_char;
    logic       done;
    logic       found;
  } tns_res_t;

endpackage

[rtl/xml_target_namespace_scanner_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_target_namespace_scanner_top
// Byte stream scanner that extracts the first targetNamespace value lying
// outside XML comments.
// ----------------------------------------------------------------------------
// One document byte is taken each cycle and its result, if any, passes
// an input register, which feeds the pattern compares and the phase
// logic, and then the result register. Each namespace character comes out
// as its own item; a done item ends the document, with found set when the
// closing quote arrived and clear when the document ended first, in which
// case any characters already delivered are to be dropped. Bytes after done
// give nothing until the byte marked end_of_doc, which returns the scanner
// to its reset state. Sustained rate is one byte per cycle; a stall on the
// output holds the input only when a byte with a result is waiting.
// ----------------------------------------------------------------------------
module xml_target_namespace_scanner_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] doc_byte_i,
  input  logic       end_of_doc_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] name_byte_o,
  output logic       is_char_o,
  output logic       done_res_o,
  output logic       found_o
);
  import tns_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_move;
  logic       in_accept;

  tns_hits_t  hits;
  tns_res_t   res;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_char_q;
  logic       out_done_q;
  logic       out_found_q;
  logic       out_load;

  // Advance the held byte unless its result has nowhere to go.
  assign s1_move    = s1_valid_q && (!res.valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = s1_move && res.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= doc_byte_i;
      s1_last_q <= end_of_doc_i;
    end
  end

  tns_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_move),
    .clear_i (s1_last_q),
    .byte_i  (s1_byte_q),
    .hits_o  (hits)
  );

  tns_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_move),
    .byte_i    (s1_byte_q),
    .last_i    (s1_last_q),
    .hits_i    (hits),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q  <= res.name_byte;
      out_char_q  <= res.is_char;
      out_done_q  <= res.done;
      out_found_q <= res.found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign name_byte_o = out_byte_q;
  assign is_char_o   = out_char_q;
  assign done_res_o  = out_done_q;
  assign found_o     = out_found_q;

endmodule

[rtl/tns_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_window
// History of recent document bytes and the fixed pattern compares that end
// on the current byte.
// ----------------------------------------------------------------------------
module tns_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               clear_i,
  input  logic [7:0]         byte_i,
  output tns_pkg::tns_hits_t hits_o
);
  import tns_pkg::*;

  logic [7:0] win_q [WinDepth];
  logic       tok_match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinDepth; i++) win_q[i] <= '0;
    end else if (shift_i) begin
      if (clear_i) begin
        for (int i = 0; i < WinDepth; i++) win_q[i] <= '0;
      end else begin
        win_q[0] <= byte_i;
        for (int i = 1; i < WinDepth; i++) win_q[i] <= win_q[i-1];
      end
    end
  end

  // Newest history byte lines up with the second to last pattern byte.
  always_comb begin
    tok_match = (byte_i == TokPat[TokLen-1]);
    for (int k = 0; k < WinDepth; k++) begin
      if (win_q[k] != TokPat[TokLen-2-k]) tok_match = 1'b0;
    end
  end

  assign hits_o.open_hit  = (byte_i == ChDash) && (win_q[0] == ChDash) &&
                            (win_q[1] == ChBang) && (win_q[2] == ChLt);
  assign hits_o.close_hit = (byte_i == ChGt) && (win_q[0] == ChDash) &&
                            (win_q[1] == ChDash);
  assign hits_o.tok_hit   = tok_match;

endmodule

[rtl/tns_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tns_fsm
// Scan phase, comment tracking and result formation for one byte a cycle,
// whenever the held byte advances.
module tns_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  tns_pkg::tns_hits_t hits_i,
  output tns_pkg::tns_res_t  res_o
);
  import tns_pkg::*;

  phase_e     phase_q, phase_d;
  logic       in_cmt_q, in_cmt_d;
  logic [1:0] since_q, since_d;
  logic       dquote_q, dquote_d;
  logic       close_quote;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      in_cmt_q <= 1'b0;
      since_q  <= '0;
      dquote_q <= 1'b0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      in_cmt_q <= in_cmt_d;
      since_q  <= since_d;
      dquote_q <= dquote_d;
    end
  end

  assign close_quote = (byte_i == (dquote_q ? ChDquote : ChSquote));

  always_comb begin
    phase_d  = phase_q;
    in_cmt_d = in_cmt_q;
    since_d  = since_q;
    dquote_d = dquote_q;
    res_o    = '0;

    case (phase_q)
      PH_SEARCH: begin
        if (hits_i.open_hit) begin
          in_cmt_d = 1'b1;
          since_d  = '0;
        end else if (in_cmt_q) begin
          if (since_q != OpenSat) since_d = since_q + 2'd1;
          // close only with all three bytes after the opener
          if (since_d == OpenSat && hits_i.close_hit) in_cmt_d = 1'b0;
        end
        if (!in_cmt_d && hits_i.tok_hit) phase_d = PH_SKIP;
        res_o.valid = last_i;
        res_o.done  = last_i;
      end
      PH_SKIP: begin
        phase_d     = PH_QUOTE;
        res_o.valid = last_i;
        res_o.done  = last_i;
      end
      PH_QUOTE: begin
        if (byte_i == ChDquote || byte_i == ChSquote) begin
          dquote_d = (byte_i == ChDquote);
          phase_d  = PH_NAME;
        end
        res_o.valid = last_i;
        res_o.done  = last_i;
      end
      PH_NAME: begin
        res_o.valid = 1'b1;
        if (close_quote) begin
          phase_d     = PH_DONE;
          res_o.done  = 1'b1;
          res_o.found = 1'b1;
        end else if (last_i) begin
          res_o.done = 1'b1;
        end else begin
          res_o.is_char   = 1'b1;
          res_o.name_byte = byte_i;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    // final byte of a document: back to the starting state
    if (last_i) begin
      phase_d  = PH_SEARCH;
      in_cmt_d = 1'b0;
      since_d  = '0;
      dquote_d = 1'b0;
    end
  end

endmodule

[sim/tb_xml_target_namespace_scanner_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_target_namespace_scanner_top
// Self-checking bench for the target namespace scanner. A short table of
// directed bytes comes first, then random documents, mostly well formed
// (filler, comments, token, quoted name) and some cut short or pure noise.
// Every accepted byte runs through a local scanner model, and each result
// taken from the block is compared with the oldest expected one. The sender
// works in bursts and the receiver stalls in random patterns, with one long
// hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_xml_target_namespace_scanner_top;
  import tns_pkg::*;

  localparam int NumItems  = 1850;
  localparam int IdleLimit = 3000;
  localparam int HoldCyc   = 300;
  localparam int HoldAt    = 800;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       is_char;
    logic       done_res;
    logic       found;
  } ns_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eod;
    logic       fixed;    // expectation typed in below
    logic       fixed_got;
    ns_res_t    fixed_res;
  } stim_t;

  localparam ns_res_t NoRes    = '0;
  localparam ns_res_t DoneMiss = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam ns_res_t DoneHit  = '{8'h00, 1'b0, 1'b1, 1'b1};

  localparam stim_t DirTab [27] = '{
    '{"x",      1'b1, 1'b1, 1'b1, DoneMiss},
    '{"t",      1'b0, 1'b0, 1'b0, NoRes},
    '{"a",      1'b0, 1'b0, 1'b0, NoRes},
    '{"r",      1'b0, 1'b0, 1'b0, NoRes},
    '{"g",      1'b0, 1'b0, 1'b0, NoRes},
    '{"e",      1'b0, 1'b0, 1'b0, NoRes},
    '{"t",      1'b0, 1'b0, 1'b0, NoRes},
    '{"N",      1'b0, 1'b0, 1'b0, NoRes},
    '{"a",      1'b0, 1'b0, 1'b0, NoRes},
    '{"m",      1'b0, 1'b0, 1'b0, NoRes},
    '{"e",      1'b0, 1'b0, 1'b0, NoRes},
    '{"s",      1'b0, 1'b0, 1'b0, NoRes},
    '{"p",      1'b0, 1'b0, 1'b0, NoRes},
    '{"a",      1'b0, 1'b0, 1'b0, NoRes},
    '{"c",      1'b0, 1'b0, 1'b0, NoRes},
    '{"e",      1'b0, 1'b0, 1'b0, NoRes},
    '{"=",      1'b0, 1'b0, 1'b0, NoRes},
    '{ChDquote, 1'b0, 1'b0, 1'b0, NoRes},
    '{8'hff,    1'b0, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b0, 1'b0}},
    '{8'h00,    1'b0, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{ChDquote, 1'b0, 1'b1, 1'b1, DoneHit},
    '{8'h80,    1'b1, 1'b1, 1'b0, NoRes},
    '{ChLt,     1'b0, 1'b0, 1'b0, NoRes},
    '{ChBang,   1'b0, 1'b0, 1'b0, NoRes},
    '{ChDash,   1'b0, 1'b0, 1'b0, NoRes},
    '{ChDash,   1'b0, 1'b0, 1'b0, NoRes},
    '{ChGt,     1'b1, 1'b1, 1'b1, DoneMiss}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] doc_byte_i;
  logic       end_of_doc_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] name_byte_o;
  logic       is_char_o;
  logic       done_res_o;
  logic       found_o;

  xml_target_namespace_scanner_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .doc_byte_i  (doc_byte_i),
    .end_of_doc_i(end_of_doc_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .name_byte_o (name_byte_o),
    .is_char_o   (is_char_o),
    .done_res_o  (done_res_o),
    .found_o     (found_o)
  );

  stim_t      stim_q [$];
  logic [7:0] doc_buf [$];
  ns_res_t    ns_exp_q [$];
  int         n_in;
  int         errors;
  int         idle_cyc;

  // Scanner model state
  phase_e     scan_phase;
  logic       in_cmt;
  logic [1:0] since_open;
  logic [7:0] hist [WinDepth];
  logic       quote_dq;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic void scan_clear();
    scan_phase = PH_SEARCH;
    in_cmt     = 1'b0;
    since_open = '0;
    quote_dq   = 1'b0;
    foreach (hist[k]) hist[k] = '0;
  endfunction

  // Advance the model by one byte; got tells whether a result comes out.
  function automatic void scan_byte(input logic [7:0] b, input logic eod,
                                    output bit got, output ns_res_t r);
    bit open_hit;
    bit close_hit;
    bit tok_hit;
    bit ended;
    int k;
    got       = 1'b0;
    r         = NoRes;
    ended     = 1'b0;
    open_hit  = (b == ChDash) && (hist[0] == ChDash) && (hist[1] == ChBang) &&
                (hist[2] == ChLt);
    close_hit = (b == ChGt) && (hist[0] == ChDash) && (hist[1] == ChDash);
    tok_hit   = (b == TokPat[TokLen-1]);
    for (k = 0; k < WinDepth; k++)
      if (hist[k] != TokPat[TokLen-2-k]) tok_hit = 1'b0;

    case (scan_phase)
      PH_SEARCH: begin
        if (open_hit) begin
          in_cmt     = 1'b1;
          since_open = '0;
        end else if (in_cmt) begin
          if (since_open < OpenSat) since_open = since_open + 2'd1;
          if (since_open == OpenSat && close_hit) in_cmt = 1'b0;
        end
        if (!in_cmt && tok_hit) scan_phase = PH_SKIP;
      end
      PH_SKIP: scan_phase = PH_QUOTE;
      PH_QUOTE: begin
        if (b == ChDquote || b == ChSquote) begin
          quote_dq   = (b == ChDquote);
          scan_phase = PH_NAME;
        end
      end
      PH_NAME: begin
        if (b == (quote_dq ? ChDquote : ChSquote)) begin
          got        = 1'b1;
          r          = DoneHit;
          ended      = 1'b1;
          scan_phase = PH_DONE;
        end else if (!eod) begin
          got = 1'b1;
          r   = '{b, 1'b1, 1'b0, 1'b0};
        end
      end
      default: begin
        scan_phase = PH_DONE;
        ended      = 1'b1;
      end
    endcase

    for (k = WinDepth - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = b;

    if (eod) begin
      if (!ended) begin
        got = 1'b1;
        r   = DoneMiss;
      end
      scan_clear();
    end
  endfunction

  function automatic void add_str(input string s);
    for (int k = 0; k < s.len(); k++) doc_buf.push_back(s[k]);
  endfunction

  function automatic void add_piece();
    case ($urandom_range(0, 9))
      0: add_str("<!--");
      1: add_str("-->");
      2: add_str("<!-->");
      3: add_str("<!---->");
      4: add_str("target");
      5: add_str(" ");
      6: add_str("--");
      default: doc_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // Build one document and append it to the stimulus, end marked on its
  // final byte.
  function automatic void build_doc();
    logic [7:0] q;
    logic [7:0] c;
    int         cut;
    stim_t      s;
    doc_buf.delete();
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(0, 6)) add_piece();
      if ($urandom_range(0, 2) == 0) begin
        add_str("<!--");
        if ($urandom_range(0, 1)) add_str("targetNamespace=\"x\"");
        repeat ($urandom_range(0, 3)) add_piece();
        if ($urandom_range(0, 4) != 0) add_str("-->");
      end
      add_str("targetNamespace");
      doc_buf.push_back(($urandom_range(0, 3) != 0) ? 8'h3d : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2))
        doc_buf.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(0, 255)));
      q = $urandom_range(0, 1) ? ChDquote : ChSquote;
      doc_buf.push_back(q);
      repeat ($urandom_range(0, 10)) begin
        c = 8'($urandom_range(0, 255));
        doc_buf.push_back((c == q) ? 8'h78 : c);
      end
      doc_buf.push_back(q);
      repeat ($urandom_range(0, 3)) doc_buf.push_back(8'($urandom_range(0, 255)));
      doc_buf.push_back(8'($urandom_range(0, 255)));
      // cut short now and then: end at a random byte anywhere in the document
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, doc_buf.size());
        doc_buf = doc_buf[0:cut-1];
      end
    end else begin
      repeat ($urandom_range(1, 25)) add_piece();
    end
    foreach (doc_buf[k]) begin
      s       = '0;
      s.b     = doc_buf[k];
      s.eod   = (k == doc_buf.size() - 1);
      stim_q.push_back(s);
    end
  endfunction

  // Sender
  initial begin : drive_main
    int burst;
    int gap;
    in_valid_i   = 1'b0;
    doc_byte_i   = '0;
    end_of_doc_i = 1'b0;
    rst_ni       = 1'b0;
    n_in         = 0;
    errors       = 0;
    scan_clear();
    foreach (DirTab[k]) stim_q.push_back(DirTab[k]);
    while (stim_q.size() < NumItems) build_doc();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    burst = 0;
    foreach (stim_q[k]) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 40);
      end
      in_valid_i   <= 1'b1;
      doc_byte_i   <= stim_q[k].b;
      end_of_doc_i <= stim_q[k].eod;
      do @(posedge clk_i); while (in_stall_o);
      burst--;
    end
    in_valid_i <= 1'b0;

    while (ns_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver
  initial begin : stall_main
    bit hold_done;
    int mode;
    int cnt;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    cnt         = 0;
    wait (rst_ni);
    forever begin
      // hold off long enough to back the block up into its input
      if (!hold_done && n_in >= HoldAt) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCyc) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= (cnt % 3 == 0);
          default: out_stall_i <= ($urandom_range(0, 9) < 8);
        endcase
        cnt++;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : in_mon
    bit      got;
    ns_res_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      scan_byte(doc_byte_i, end_of_doc_i, got, r);
      if (stim_q[n_in].fixed) begin
        got = stim_q[n_in].fixed_got;
        r   = stim_q[n_in].fixed_res;
      end
      if (got) ns_exp_q.push_back(r);
      n_in++;
    end
  end

  always @(posedge clk_i) begin : out_mon
    ns_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ns_exp_q.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t: unexpected result byte=%h char=%b done=%b found=%b",
                   $time, name_byte_o, is_char_o, done_res_o, found_o);
      end else begin
        want = ns_exp_q.pop_front();
        if (name_byte_o !== want.name_byte || is_char_o !== want.is_char ||
            done_res_o !== want.done_res || found_o !== want.found) begin
          errors++;
          if (errors < 50)
            $display("%0t: mismatch exp %h %b %b %b got %h %b %b %b", $time,
                     want.name_byte, want.is_char, want.done_res, want.found,
                     name_byte_o, is_char_o, done_res_o, found_o);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule
